// ===== sv/spq_pkg.sv =====
// Shared constants, types and codes for the sorted priority queue.
package spq_pkg;

  localparam int DEPTH       = 8;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int STEP_W      = $clog2(DEPTH);
  localparam int COUNT_OUT_W = 4;
  localparam int OUT_DATA_W  = ((DATA_W + COUNT_OUT_W + 7) / 8) * 8;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_DUMP = 1'b1
  } fsm_state_e;

  typedef struct packed {
    cell_op_e op;
    data_t    key;
  } chain_cmd_t;

endpackage

// ===== sv/spq_cell.sv =====
// One storage cell of the sorted chain: holds one entry and trades with its neighbors.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::chain_cmd_t cmd,
  input  logic               in_range,
  input  logic               left_flag,
  input  spq_pkg::data_t     left_entry,
  input  spq_pkg::data_t     right_entry,
  input  logic               hit_in,
  output spq_pkg::data_t     entry,
  output logic               flag,
  output logic               hit_out
);
  import spq_pkg::*;

  logic match;

  // The flag marks cells at or after the insert point; it is monotonic along the chain.
  assign flag    = !in_range || ($signed(cmd.key) >= $signed(entry));
  assign match   = in_range && (entry == cmd.key);
  assign hit_out = hit_in || match;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CELL_INSERT: begin
        if (left_flag) begin
          entry <= left_entry;
        end else if (flag) begin
          entry <= cmd.key;
        end
      end
      CELL_DELETE: begin
        if (hit_out) begin
          entry <= right_entry;
        end
      end
      CELL_ROTATE: begin
        entry <= right_entry;
      end
      CELL_HOLD: begin
        entry <= entry;
      end
      default: begin
        entry <= entry;
      end
    endcase
  end

endmodule

// ===== sv/spq_chain.sv =====
// Row of storage cells wired as a ring, with the delete match rippling from the head.
module spq_chain (
  input  logic                clk,
  input  spq_pkg::chain_cmd_t cmd,
  input  spq_pkg::cnt_t       count,
  output spq_pkg::data_t      head,
  output logic                found
);
  import spq_pkg::*;

  data_t entries [DEPTH];
  logic  flags   [DEPTH];
  logic  hits    [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic  in_range;
    logic  left_flag;
    data_t left_entry;
    data_t right_entry;
    logic  hit_in;

    assign in_range = CNT_W'(i) < count;

    if (i == 0) begin : g_head
      assign left_flag  = 1'b0;
      assign left_entry = '0;
      assign hit_in     = 1'b0;
    end else begin : g_body
      assign left_flag  = flags[i-1];
      assign left_entry = entries[i-1];
      assign hit_in     = hits[i-1];
    end

    // The tail closes the ring so a dump rotation brings every entry back home.
    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = entries[0];
    end else begin : g_mid
      assign right_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .in_range    (in_range),
      .left_flag   (left_flag),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .hit_in      (hit_in),
      .entry       (entries[i]),
      .flag        (flags[i]),
      .hit_out     (hits[i])
    );
  end

  assign head  = entries[0];
  assign found = hits[DEPTH-1];

endmodule

// ===== sv/sorted_priority_queue_top.sv =====
// Sorted priority queue: a ring of cells kept in descending order, with stream ports.
// Insert, delete and the unused opcode each give one item, in the cycle after they are accepted.
// A dump of a non-empty queue holds the input off for one full rotation of the
// cell ring, plus any output stall; it emits one item per stored entry (or one empty item).
// Reset (rst, synchronous, active high) empties the queue and marks the output register empty;
// the cell contents are not reset since only entries below the count are ever read.
module sorted_priority_queue_top (
  input  logic        clk,
  input  logic        rst,
  // Input item.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  // Result item.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [spq_pkg::OUT_DATA_W-1:0] m_tdata,  // [31:0] entry, [35:32] entry_count
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic        m_tlast
);
  import spq_pkg::*;

  // Control state.
  fsm_state_e state, state_next;
  cnt_t       count, count_next;
  step_t      step, step_next;
  logic       out_valid;

  // Output register payload.
  status_e out_status;
  data_t   out_entry;
  cnt_t    out_count;
  logic    out_last;

  // Values loaded into the output register this cycle.
  logic    load_out;
  status_e ld_status;
  data_t   ld_entry;
  logic    ld_last;

  logic       out_free;
  logic       accept;
  logic       emit;
  chain_cmd_t cmd;
  data_t      head;
  logic       found;

  // The output slot can take a new item when empty or when its item leaves this cycle.
  assign out_free = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign emit     = CNT_W'(step) < count;

  spq_chain u_chain (
    .clk   (clk),
    .cmd   (cmd),
    .count (count),
    .head  (head),
    .found (found)
  );

  always_comb begin
    state_next = state;
    count_next = count;
    step_next  = step;
    // The key always follows the input bus; only the cell operation is gated.
    cmd.key    = s_tdata;
    cmd.op     = CELL_HOLD;
    load_out   = 1'b0;
    ld_status  = ST_OK;
    ld_entry   = '0;
    ld_last    = 1'b1;
    s_tready   = 1'b0;

    unique case (state)
      FSM_IDLE: begin
        s_tready = out_free;
        if (accept) begin
          load_out = 1'b1;
          unique case (s_tuser)
            OP_INSERT: begin
              if (count == CNT_W'(DEPTH)) begin
                ld_status = ST_FULL;
              end else begin
                cmd.op     = CELL_INSERT;
                count_next = count + CNT_W'(1);
              end
            end
            OP_DELETE: begin
              if (count == '0) begin
                ld_status = ST_EMPTY;
              end else if (found) begin
                cmd.op     = CELL_DELETE;
                count_next = count - CNT_W'(1);
              end else begin
                ld_status = ST_NOTFOUND;
              end
            end
            OP_DUMP: begin
              if (count == '0) begin
                ld_status = ST_EMPTY;
              end else begin
                // Entries are emitted by the dump sequence instead.
                load_out   = 1'b0;
                state_next = FSM_DUMP;
                step_next  = '0;
              end
            end
            default: begin
              ld_status = ST_OK;
            end
          endcase
        end
      end
      FSM_DUMP: begin
        // While emitting, the ring only turns when the head entry can be sent.
        // Past the last stored entry it keeps turning until it is back home.
        if (!emit || out_free) begin
          cmd.op = CELL_ROTATE;
          if (emit) begin
            load_out = 1'b1;
            ld_entry = head;
            ld_last  = (CNT_W'(step) + CNT_W'(1)) == count;
          end
          if (step == STEP_W'(DEPTH - 1)) begin
            state_next = FSM_IDLE;
            step_next  = '0;
          end else begin
            step_next = step + STEP_W'(1);
          end
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FSM_IDLE;
      count     <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      step  <= step_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= ld_status;
      out_entry  <= ld_entry;
      out_count  <= count_next;
      out_last   <= ld_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;
  assign m_tdata  = {(OUT_DATA_W - DATA_W - COUNT_OUT_W)'(0),
                     COUNT_OUT_W'(out_count), out_entry};

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the sorted priority queue, driven through its stream ports.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  // Opcode 3 is not used by the block. It must behave as a no-op that still returns one item.
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         HOLD_CYCLES = 150;
  localparam int         MAX_PRINTED = 30;

  // One result item as the block should emit it.
  typedef struct {
    status_e    status;
    data_t      entry;
    logic [3:0] entry_count;
    logic       last;
  } queue_result_t;

  // Shadow copy of the queue. It works out the result items of every accepted item and
  // compares them, in order, with the items that the block emits.
  class sorted_queue_shadow;
    int            shadow_entries[$];
    queue_result_t pending_results[$];
    int unsigned   error_count;
    int unsigned   result_index;

    function void push_result(status_e st, int e, bit is_last);
      queue_result_t r;
      r.status      = st;
      r.entry       = e;
      r.entry_count = 4'(shadow_entries.size());
      r.last        = is_last;
      pending_results.push_back(r);
    endfunction

    function void note_command(logic [1:0] op, int v);
      int pos;
      pos = 0;
      case (op)
        OP_INSERT: begin
          if (shadow_entries.size() >= DEPTH) begin
            push_result(ST_FULL, 0, 1'b1);
          end else begin
            // A new value goes ahead of the first entry that is less than or equal to it.
            while (pos < shadow_entries.size() && v < shadow_entries[pos]) pos++;
            shadow_entries.insert(pos, v);
            push_result(ST_OK, 0, 1'b1);
          end
        end
        OP_DELETE: begin
          if (shadow_entries.size() == 0) begin
            push_result(ST_EMPTY, 0, 1'b1);
          end else begin
            while (pos < shadow_entries.size() && shadow_entries[pos] != v) pos++;
            if (pos == shadow_entries.size()) begin
              push_result(ST_NOTFOUND, 0, 1'b1);
            end else begin
              shadow_entries.delete(pos);
              push_result(ST_OK, 0, 1'b1);
            end
          end
        end
        OP_DUMP: begin
          if (shadow_entries.size() == 0) begin
            push_result(ST_EMPTY, 0, 1'b1);
          end else begin
            foreach (shadow_entries[k])
              push_result(ST_OK, shadow_entries[k], k == shadow_entries.size() - 1);
          end
        end
        default: push_result(ST_OK, 0, 1'b1);
      endcase
    endfunction

    task report(string msg);
      error_count++;
      if (error_count <= MAX_PRINTED) $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task check_result(logic [1:0] st, data_t e, logic [3:0] c, logic l);
      queue_result_t want;
      result_index++;
      if (pending_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing pending", result_index));
      end else begin
        want = pending_results.pop_front();
        if (st !== want.status)
          report($sformatf("result %0d status %0d, expected %0d", result_index, st,
                           want.status));
        if (e !== want.entry)
          report($sformatf("result %0d entry %0d, expected %0d", result_index,
                           $signed(e), $signed(want.entry)));
        if (c !== want.entry_count)
          report($sformatf("result %0d entry_count %0d, expected %0d", result_index, c,
                           want.entry_count));
        if (l !== want.last)
          report($sformatf("result %0d last %0b, expected %0b", result_index, l, want.last));
      end
    endtask

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata  = '0;
  logic [1:0]            s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;
  logic                  m_tlast;

  sorted_queue_shadow shadow = new();

  // Idle rates in percent, changed by the main sequence between phases.
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;

  // A request for one long receiver hold-off, counted down by the receiver itself.
  logic        hold_arm  = 1'b0;
  int unsigned hold_left = 0;

  sorted_priority_queue_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off when the main sequence asks for it.
  // During the hold-off the sender keeps offering items, so the block backs up and
  // drops s_tready.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_arm) begin
      m_tready  <= 1'b0;
      hold_arm  <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else begin
      m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Every accepted result item is checked against the oldest pending prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      shadow.check_result(m_tuser, m_tdata[31:0], m_tdata[35:32], m_tlast);
  end

  // Offers one item, with a random gap in front of it, and waits until it is accepted.
  // The task returns at the accepting edge, so a following item can keep tvalid high.
  task automatic send_item(logic [1:0] op, int v);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    shadow.note_command(op, v);
  endtask

  // The sender stops and waits until every predicted result item has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  // Nearly half of the values are drawn from a narrow range so that duplicates and delete hits
  // are common; the rest are extremes and full-width random words.
  function automatic int pick_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45) return $urandom_range(8) - 4;
    if (roll < 60) begin
      case ($urandom_range(3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return -1;
        default: return 0;
      endcase
    end
    return $urandom;
  endfunction

  // Mostly inserts and deletes of stored values, so the queue spends most of its
  // time partly or completely full; dumps, misses and the unused opcode are mixed in.
  task automatic send_random(int num_items);
    logic [1:0]  op;
    int          v;
    int unsigned roll;
    int          stored;
    for (int n = 0; n < num_items; n++) begin
      roll   = $urandom_range(99);
      v      = pick_value();
      stored = shadow.shadow_entries.size();
      if (roll < 3) begin
        op = OP_UNUSED;
      end else if (roll < 15) begin
        op = OP_DUMP;
      end else if (roll < ((stored < DEPTH) ? 60 : 45)) begin
        op = OP_INSERT;
      end else begin
        op = OP_DELETE;
        if (stored != 0 && $urandom_range(99) < 70)
          v = shadow.shadow_entries[$urandom_range(stored - 1)];
      end
      send_item(op, v);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: the empty queue first, then extremes, ties, a full queue and removals
    // at the head, the tail and the middle.
    send_item(OP_DUMP, 32'h0000_1234);
    send_item(OP_DELETE, 5);
    send_item(OP_UNUSED, 9);
    send_item(OP_INSERT, 32'h7FFF_FFFF);
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_INSERT, 0);
    send_item(OP_INSERT, -1);
    send_item(OP_INSERT, 0);
    send_item(OP_INSERT, 1);
    send_item(OP_DELETE, 7);
    send_item(OP_INSERT, 5);
    send_item(OP_INSERT, -5);
    send_item(OP_INSERT, 3);
    send_item(OP_DUMP, -1);
    send_item(OP_DELETE, 32'h8000_0000);
    send_item(OP_DELETE, 32'h7FFF_FFFF);
    send_item(OP_DELETE, 0);
    send_item(OP_INSERT, 32'h7FFF_FFFF);
    send_item(OP_UNUSED, -1);
    send_item(OP_DUMP, 0);
    wait_drained();

    // Random phases. The first one also holds the receiver off for a long stretch.
    hold_arm <= 1'b1;
    send_random(35);
    wait_drained();

    sender_idle_pct    = 45;
    receiver_stall_pct = 0;
    send_random(35);
    wait_drained();

    sender_idle_pct    = 0;
    receiver_stall_pct = 45;
    send_random(35);
    wait_drained();

    sender_idle_pct    = 33;
    receiver_stall_pct = 33;
    send_random(35);
    wait_drained();

    // Let any stray result item show up before the verdict.
    repeat (2 * DEPTH + 20) @(posedge clk);
    if (shadow.error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/spq_pkg.sv
sv/spq_cell.sv
sv/spq_chain.sv
sv/sorted_priority_queue_top.sv
sim/testbench.sv
